@@ hw/rtl/utf8_byte_stream_decoder_top_assert.svh @@
// Assertion macros shared by the decoder checker.
// Clocked concurrent assertions, with and without a reset guard.
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH

// Assertion disabled while reset is held low.
`define UTF8_DEC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion checked at every edge, reset included.
`define UTF8_DEC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/utf8_dec_pkg.sv @@
// Types and constants for the UTF-8 byte stream decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package utf8_dec_pkg;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_BAD  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] CONT_MASK  = 8'h3f;
    localparam logic [7:0] LEAD2_MASK = 8'h1f;
    localparam logic [7:0] LEAD3_MASK = 8'h0f;
    localparam logic [7:0] LEAD4_MASK = 8'h07;
    localparam logic [7:0] LEAD5_MASK = 8'h03;
    localparam logic [7:0] LEAD6_MASK = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_t;

    typedef struct packed {
        logic [30:0] code_point;
        logic [1:0]  kind;
        logic        final_res;
    } out_t;

    typedef struct packed {
        logic [30:0] partial_value;
        logic [2:0]  bytes_remaining;
        logic        halted;
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/utf8_dec_step.sv @@
// Per-byte decode step: next state and optional result from current state.
// Depends on utf8_dec_pkg.
`default_nettype none

module utf8_dec_step (
    input  utf8_dec_pkg::state_t st,
    input  utf8_dec_pkg::in_t    req,
    output utf8_dec_pkg::state_t st_next,
    output logic                 res_valid,
    output utf8_dec_pkg::out_t   res
);

    logic [7:0]  b;
    logic        fin;
    logic        bad;
    logic        lead_ok;
    logic [30:0] payload;
    logic [2:0]  due;
    logic [30:0] shifted;
    logic [2:0]  rem_dec;

    assign b       = req.data_byte;
    assign fin     = req.end_of_string;
    assign shifted = {st.partial_value[24:0], b[5:0]};
    assign rem_dec = st.bytes_remaining - 3'd1;

    always_comb begin
        lead_ok = 1'b1;
        payload = '0;
        due     = 3'd0;
        priority if (b[7:5] == 3'b110) begin
            payload = {23'd0, b & utf8_dec_pkg::LEAD2_MASK};
            due     = 3'd1;
        end else if (b[7:4] == 4'b1110) begin
            payload = {23'd0, b & utf8_dec_pkg::LEAD3_MASK};
            due     = 3'd2;
        end else if (b[7:3] == 5'b11110) begin
            payload = {23'd0, b & utf8_dec_pkg::LEAD4_MASK};
            due     = 3'd3;
        end else if (b[7:2] == 6'b111110) begin
            payload = {23'd0, b & utf8_dec_pkg::LEAD5_MASK};
            due     = 3'd4;
        end else if (b[7:1] == 7'b1111110) begin
            payload = {23'd0, b & utf8_dec_pkg::LEAD6_MASK};
            due     = 3'd5;
        end else begin
            lead_ok = 1'b0;
        end
    end

    always_comb begin
        st_next        = st;
        res_valid      = 1'b0;
        res.code_point = '0;
        res.kind       = utf8_dec_pkg::KIND_CHAR;
        res.final_res  = fin;
        bad            = 1'b0;

        if (st.halted) begin
            if (fin) begin
                st_next   = '0;
                res_valid = 1'b1;
                res.kind  = utf8_dec_pkg::KIND_END;
            end
        end else if (st.bytes_remaining == 3'd0) begin
            priority if (!b[7]) begin
                res_valid      = 1'b1;
                res.code_point = {23'd0, b};
            end else if (b[6] == 1'b0 || !lead_ok || fin) begin
                bad = 1'b1;
            end else begin
                st_next.partial_value   = payload;
                st_next.bytes_remaining = due;
            end
        end else begin
            priority if (b[7:6] != 2'b10) begin
                bad = 1'b1;
            end else if (rem_dec == 3'd0) begin
                res_valid               = 1'b1;
                res.code_point          = shifted;
                st_next.partial_value   = '0;
                st_next.bytes_remaining = 3'd0;
            end else if (fin) begin
                bad = 1'b1;
            end else begin
                st_next.partial_value   = shifted;
                st_next.bytes_remaining = rem_dec;
            end
        end

        if (bad) begin
            st_next        = '0;
            st_next.halted = !fin;
            res_valid      = 1'b1;
            res.code_point = '0;
            res.kind       = utf8_dec_pkg::KIND_BAD;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/utf8_byte_stream_decoder_top.sv @@
// UTF-8 byte stream decoder, top level: state registers and result buffer.
// Depends on utf8_dec_pkg and utf8_dec_step.
//
// Takes one byte per clock while s_ready is high and gives at most one
// result per byte, registered in the output register when no earlier
// result is left waiting. The original 1 to 6 byte forms are decoded
// without overlong checks; after a malformed sequence, bytes are dropped up
// to the end of the string, which then gives an end marker. Sustained rate
// is one byte per cycle, set by the single decode step between the state
// registers and the result register. A two-entry result buffer (output
// register plus skid register) lets bytes keep flowing while a result waits;
// s_ready falls only while both entries are full.
`default_nettype none

module utf8_byte_stream_decoder_top (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  utf8_dec_pkg::in_t   s_payload,
    output logic                m_valid,
    input  wire                 m_ready,
    output utf8_dec_pkg::out_t  m_payload
);

    utf8_dec_pkg::state_t state_reg;
    utf8_dec_pkg::state_t state_next;
    logic                 res_valid;
    utf8_dec_pkg::out_t   res;

    logic                 out_valid_reg;
    utf8_dec_pkg::out_t   out_data_reg;
    logic                 skid_valid_reg;
    utf8_dec_pkg::out_t   skid_data_reg;

    logic                 accept;
    logic                 pop;
    logic                 push;

    utf8_dec_step u_step (
        .st        (state_reg),
        .req       (s_payload),
        .st_next   (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign push      = accept && res_valid;
    assign pop       = out_valid_reg && m_ready;
    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_data_reg <= res;
            end else begin
                out_data_reg <= res;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/utf8_dec_checker.sv @@
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8_dec_pkg and utf8_byte_stream_decoder_top_assert.svh.
`default_nettype none

`include "utf8_byte_stream_decoder_top_assert.svh"

module utf8_dec_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  utf8_dec_pkg::in_t   s_payload,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  utf8_dec_pkg::out_t  m_payload
);

    `UTF8_DEC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result after reset")

    `UTF8_DEC_ASSERT(a_stall_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_payload),
        "stalled result changed")

    `UTF8_DEC_ASSERT(a_zero_cp, aclk, aresetn,
        m_valid && m_payload.kind != utf8_dec_pkg::KIND_CHAR |-> m_payload.code_point == 31'd0,
        "non-character result with code point")

    `UTF8_DEC_ASSERT(a_end_final, aclk, aresetn,
        m_valid && m_payload.kind == utf8_dec_pkg::KIND_END |-> m_payload.final_res,
        "end marker without final flag")

    `UTF8_DEC_ASSERT(a_last_byte_result, aclk, aresetn,
        s_valid && s_ready && s_payload.end_of_string |=> m_valid,
        "last byte gave no result")

endmodule

bind utf8_byte_stream_decoder_top utf8_dec_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire
